// ----- rtl/buddy_allocator_tree_macros.svh -----
// Assertion helpers shared by the allocator RTL.
// Both expect clk and rst_n in scope; checks are off while reset is low.
`ifndef BUDDY_ALLOCATOR_TREE_MACROS_SVH
`define BUDDY_ALLOCATOR_TREE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BAT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bat_pkg.sv -----
`default_nettype none

package bat_pkg;

  localparam int POOL_UNITS = 256;
  localparam int LVL        = $clog2(POOL_UNITS);
  localparam int TREE_NODES = 2 * POOL_UNITS - 1;
  localparam int NODE_W     = $clog2(TREE_NODES);
  localparam int VAL_W      = LVL + 1;

  localparam int REQ_W      = 9;
  localparam int OFF_W      = 8;
  localparam int STATUS_W   = 2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [VAL_W-1:0]  val_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NOSPACE = 2'd1,
    STAT_IGNORED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_A_ROOT,
    S_A_DESC,
    S_F_CLIMB,
    S_ASC,
    S_RESP
  } state_t;

  // Round a request up to a power of two; zero counts as one.
  function automatic logic [REQ_W:0] round_pow2(input logic [REQ_W-1:0] req);
    logic [REQ_W-1:0]           m;
    logic [$clog2(REQ_W+1)-1:0] bl;
    m  = (req == '0) ? '0 : req - REQ_W'(1);
    bl = '0;
    for (int i = 0; i < REQ_W; i++) begin
      if (m[i]) begin
        bl = ($clog2(REQ_W+1))'(i + 1);
      end
    end
    return (REQ_W+1)'(1) << bl;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/bat_if.sv -----
`default_nettype none

// Request channel: one beat per allocate or free.
interface bat_req_if;
  import bat_pkg::*;

  logic             valid;
  logic             ready;
  logic             mode;
  logic [REQ_W-1:0] request_size;
  logic [OFF_W-1:0] block_offset;

  modport source (output valid, output mode, output request_size, output block_offset,
                  input ready);
  modport sink   (input valid, input mode, input request_size, input block_offset,
                  output ready);
endinterface

// Response channel: one beat per request.
interface bat_rsp_if;
  import bat_pkg::*;

  logic                valid;
  logic                ready;
  logic [OFF_W-1:0]    granted_offset;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output granted_offset, output status, input ready);
  modport sink   (input valid, input granted_offset, input status, output ready);
endinterface

`default_nettype wire

// ----- rtl/bat_tree_ram.sv -----
`default_nettype none

// Simple dual-port RAM: one write port, one registered read port.
module bat_tree_ram #(
  parameter  int DEPTH = 511,
  parameter  int WIDTH = 9,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/buddy_allocator_tree.sv -----
`default_nettype none
`include "buddy_allocator_tree_macros.svh"

// Binary buddy allocator over a pool of POOL_UNITS units (256 as built). The
// free-space tree (2*POOL_UNITS-1 nodes, each holding the largest free block
// beneath it) lives in one dual-port RAM with a registered read. An allocate
// rounds the request up to a power of two (zero counts as one), walks down
// from the root to the leftmost fitting node, zeroes it and refreshes its
// ancestors; it returns the block's unit offset with status 0, or status 1
// when nothing fits. A free climbs from the leaf of block_offset to the first
// allocated node, restores it and merges buddies on the way back up; status 2
// means the offset was not allocated. Every request gets exactly one response
// beat. The walk costs one RAM access per tree level each way. Between its
// climb and its merge a free covers all LVL levels wherever it stops, ignored
// or not. One request is in flight at a time; the next is accepted once the
// previous response is loaded into the output register, even while that
// register still waits for out_rsp.ready.
// After reset the block sweeps the RAM to its initial sizes, one node per
// cycle, over all 2*POOL_UNITS-1 nodes before it accepts the first beat.
module buddy_allocator_tree (
  input  logic         clk,
  input  logic         rst_n,
  bat_req_if.sink      in_req,
  bat_rsp_if.source    out_rsp
);
  import bat_pkg::*;

  // Tree index helpers (root at 0, children of k at 2k+1 and 2k+2).
  function automatic node_t left_of(input node_t n);
    return {n[NODE_W-2:0], 1'b1};
  endfunction

  function automatic node_t parent_of(input node_t n);
    return (n - NODE_W'(1)) >> 1;
  endfunction

  function automatic node_t sibling_of(input node_t n);
    return n[0] ? n + NODE_W'(1) : n - NODE_W'(1);
  endfunction

  // Control state
  state_t  state_r, state_nxt;
  node_t   clr_addr_r, clr_addr_nxt;
  val_t    clr_val_r, clr_val_nxt;
  logic    out_valid_r, out_valid_nxt;

  // Per-request working registers
  node_t            node_r, node_nxt;     // node under inspection
  val_t             size_r, size_nxt;     // full size of that node
  val_t             want_r, want_nxt;     // rounded allocate size
  val_t             known_r, known_nxt;   // value just written at node_r
  logic [LVL-1:0]   off_r, off_nxt;       // offset of the node on the way down
  logic             mode_r, mode_nxt;
  status_t          stat_r, stat_nxt;

  logic [OFF_W-1:0] out_off_r, out_off_nxt;
  status_t          out_stat_r, out_stat_nxt;

  // RAM port
  logic  mem_we, mem_re;
  node_t mem_waddr, mem_raddr;
  val_t  mem_wdata, mem_rdata;

  bat_tree_ram #(
    .DEPTH (TREE_NODES),
    .WIDTH (VAL_W)
  ) u_tree_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Request decode
  logic [REQ_W:0] want_in;
  logic           want_fits;
  logic           off_in_pool;
  node_t          leaf_node;

  assign want_in     = round_pow2(in_req.request_size);
  assign want_fits   = int'(want_in) <= POOL_UNITS;
  assign off_in_pool = int'(in_req.block_offset) < POOL_UNITS;
  assign leaf_node   = NODE_W'(POOL_UNITS - 1) + NODE_W'(in_req.block_offset);

  // Descent step: go left when the left child is big enough
  val_t  half;
  logic  go_right;
  node_t desc_node;

  assign half      = size_r >> 1;
  assign go_right  = mem_rdata < want_r;
  assign desc_node = go_right ? left_of(node_r) + NODE_W'(1) : left_of(node_r);

  // Ascent step: combine the known child with its sibling from RAM
  node_t          up_node;
  val_t           up_size;
  logic [VAL_W:0] pair_sum;
  val_t           pair_max;
  val_t           up_val;

  assign up_node  = parent_of(node_r);
  assign up_size  = size_r << 1;
  assign pair_sum = {1'b0, known_r} + {1'b0, mem_rdata};
  assign pair_max = (known_r > mem_rdata) ? known_r : mem_rdata;
  assign up_val   = (mode_r == MODE_FREE && pair_sum == {1'b0, up_size}) ? up_size
                                                                         : pair_max;

  // Clear sweep: halve the written size whenever the next node opens a level
  logic [NODE_W:0] clr_kp1, clr_kp2;

  assign clr_kp1 = {1'b0, clr_addr_r} + (NODE_W+1)'(1);
  assign clr_kp2 = clr_kp1 + (NODE_W+1)'(1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == NODE_W'(TREE_NODES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_req.valid) begin
          if (in_req.mode == MODE_ALLOC) begin
            state_nxt = want_fits ? S_A_ROOT : S_RESP;
          end else begin
            state_nxt = off_in_pool ? S_F_CLIMB : S_RESP;
          end
        end
      end
      S_A_ROOT: begin
        if (mem_rdata < want_r || want_r == size_r) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_A_DESC;
        end
      end
      S_A_DESC: begin
        if (half == want_r) begin
          state_nxt = S_ASC;
        end
      end
      S_F_CLIMB: begin
        if (mem_rdata == '0) begin
          state_nxt = (node_r == '0) ? S_RESP : S_ASC;
        end else if (node_r == '0) begin
          state_nxt = S_RESP;
        end
      end
      S_ASC: begin
        if (up_node == '0) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_rsp.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, RAM controls and response register
  always_comb begin
    clr_addr_nxt  = clr_addr_r;
    clr_val_nxt   = clr_val_r;
    node_nxt      = node_r;
    size_nxt      = size_r;
    want_nxt      = want_r;
    known_nxt     = known_r;
    off_nxt       = off_r;
    mode_nxt      = mode_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_off_nxt   = out_off_r;
    out_stat_nxt  = out_stat_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;

    case (state_r)
      S_CLEAR: begin
        // Write each node's full size, level by level
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = clr_val_r;
        clr_addr_nxt = clr_addr_r + NODE_W'(1);
        if ((clr_kp2 & clr_kp1) == '0) begin
          clr_val_nxt = clr_val_r >> 1;
        end
      end
      S_IDLE: begin
        if (in_req.valid) begin
          mode_nxt  = in_req.mode;
          stat_nxt  = STAT_OK;
          off_nxt   = '0;
          known_nxt = '0;
          if (in_req.mode == MODE_ALLOC) begin
            want_nxt = VAL_W'(want_in);
            node_nxt = '0;
            size_nxt = VAL_W'(POOL_UNITS);
            if (want_fits) begin
              mem_re    = 1'b1;
              mem_raddr = '0;
            end else begin
              stat_nxt = STAT_NOSPACE;
            end
          end else begin
            node_nxt = leaf_node;
            size_nxt = VAL_W'(1);
            if (off_in_pool) begin
              mem_re    = 1'b1;
              mem_raddr = leaf_node;
            end else begin
              stat_nxt = STAT_IGNORED;
            end
          end
        end
      end
      S_A_ROOT: begin
        if (mem_rdata < want_r) begin
          stat_nxt = STAT_NOSPACE;
        end else if (want_r == size_r) begin
          // Whole pool: mark the root, no ancestors to refresh
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = '0;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = left_of(node_r);
        end
      end
      S_A_DESC: begin
        node_nxt = desc_node;
        size_nxt = half;
        if (go_right) begin
          off_nxt = off_r + LVL'(half);
        end
        if (half == want_r) begin
          // Mark the block used, fetch its buddy for the climb back up
          mem_we    = 1'b1;
          mem_waddr = desc_node;
          mem_wdata = '0;
          known_nxt = '0;
          mem_re    = 1'b1;
          mem_raddr = sibling_of(desc_node);
        end else begin
          mem_re    = 1'b1;
          mem_raddr = left_of(desc_node);
        end
      end
      S_F_CLIMB: begin
        if (mem_rdata == '0) begin
          // Found the allocated node: restore its size
          mem_we    = 1'b1;
          mem_waddr = node_r;
          mem_wdata = size_r;
          known_nxt = size_r;
          if (node_r != '0) begin
            mem_re    = 1'b1;
            mem_raddr = sibling_of(node_r);
          end
        end else if (node_r == '0) begin
          stat_nxt = STAT_IGNORED;
        end else begin
          node_nxt  = up_node;
          size_nxt  = up_size;
          mem_re    = 1'b1;
          mem_raddr = up_node;
        end
      end
      S_ASC: begin
        mem_we    = 1'b1;
        mem_waddr = up_node;
        mem_wdata = up_val;
        node_nxt  = up_node;
        size_nxt  = up_size;
        known_nxt = up_val;
        if (up_node != '0) begin
          mem_re    = 1'b1;
          mem_raddr = sibling_of(up_node);
        end
      end
      S_RESP: begin
        // Load the beat once the output register is free
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          out_off_nxt   = OFF_W'(off_r);
          out_stat_nxt  = stat_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      clr_val_r   <= VAL_W'(POOL_UNITS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_val_r   <= clr_val_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    node_r     <= node_nxt;
    size_r     <= size_nxt;
    want_r     <= want_nxt;
    known_r    <= known_nxt;
    off_r      <= off_nxt;
    mode_r     <= mode_nxt;
    stat_r     <= stat_nxt;
    out_off_r  <= out_off_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign in_req.ready           = (state_r == S_IDLE);
  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.granted_offset = out_off_r;
  assign out_rsp.status         = out_stat_r;

  // A read never targets the node being written in the same cycle
  `BAT_ASSERT_NOW(a_no_rw_collide, mem_we && mem_re, mem_waddr != mem_raddr,
                  "tree RAM read and write hit one node")
  // The walk down stops at the wanted size, never below it
  `BAT_ASSERT_NOW(a_desc_above_want, state_r == S_A_DESC, size_r > want_r,
                  "descent passed the wanted size")
  // A refused request reports offset zero
  `BAT_ASSERT_NOW(a_fail_zero_off, out_rsp.valid && out_rsp.status != STAT_OK,
                  out_rsp.granted_offset == '0, "nonzero offset on a refused request")
  // An accepted beat starts work right away
  `BAT_ASSERT_NEXT(a_accept_leaves_idle, in_req.valid && in_req.ready, state_r != S_IDLE,
                   "accepted beat left the sequencer idle")

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bat_pkg::*;

  // Run length guard: covers the worst beat (a full tree walk, the longest sender
  // gap and the longest receiver stall) for every beat, plus the reset sweep.
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_BEATS = 400;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic             mode;
    logic [REQ_W-1:0] size;
    logic [OFF_W-1:0] off;
  } req_t;

  typedef struct packed {
    logic [OFF_W-1:0] off;
    status_t          st;
  } rsp_t;

  // One directed row: the request, and a hand-typed response where the answer
  // is obvious. Rows with typed = 0 are checked against the tree model.
  typedef struct packed {
    logic             mode;
    logic [REQ_W-1:0] size;
    logic [OFF_W-1:0] off;
    logic             typed;
    logic [OFF_W-1:0] exp_off;
    status_t          exp_st;
  } dir_row_t;

  // A block the model says is granted: its offset and the size asked for.
  typedef struct packed {
    logic [OFF_W-1:0] off;
    logic [REQ_W-1:0] len;
  } held_t;

  localparam int DIR_ROWS = 23;

  dir_row_t directed_rows [DIR_ROWS] = '{
    // free on a fresh pool: nothing allocated, so ignored (both offset extremes)
    '{MODE_FREE,  9'd0,   8'd0,   1'b1, 8'd0, STAT_IGNORED},
    '{MODE_FREE,  9'd0,   8'd255, 1'b1, 8'd0, STAT_IGNORED},
    // requests above the pool size after rounding
    '{MODE_ALLOC, 9'd511, 8'd0,   1'b1, 8'd0, STAT_NOSPACE},
    '{MODE_ALLOC, 9'd257, 8'd0,   1'b1, 8'd0, STAT_NOSPACE},
    // zero counts as one unit and lands at the leftmost leaf
    '{MODE_ALLOC, 9'd0,   8'd0,   1'b1, 8'd0, STAT_OK},
    // whole pool no longer fits
    '{MODE_ALLOC, 9'd256, 8'd0,   1'b1, 8'd0, STAT_NOSPACE},
    '{MODE_ALLOC, 9'd1,   8'd0,   1'b0, 8'd0, STAT_OK},
    '{MODE_FREE,  9'd0,   8'd0,   1'b0, 8'd0, STAT_OK},
    '{MODE_FREE,  9'd0,   8'd1,   1'b0, 8'd0, STAT_OK},
    // buddies merged back: the full pool is granted; offset field is ignored
    '{MODE_ALLOC, 9'd256, 8'd255, 1'b1, 8'd0, STAT_OK},
    '{MODE_ALLOC, 9'd1,   8'd0,   1'b1, 8'd0, STAT_NOSPACE},
    // free from inside the block releases the whole block, then a repeat is ignored
    '{MODE_FREE,  9'd0,   8'd200, 1'b0, 8'd0, STAT_OK},
    '{MODE_FREE,  9'd511, 8'd200, 1'b0, 8'd0, STAT_OK},
    '{MODE_ALLOC, 9'd3,   8'd0,   1'b0, 8'd0, STAT_OK},
    '{MODE_ALLOC, 9'd1,   8'd0,   1'b0, 8'd0, STAT_OK},
    '{MODE_ALLOC, 9'd128, 8'd0,   1'b0, 8'd0, STAT_OK},
    '{MODE_ALLOC, 9'd64,  8'd0,   1'b0, 8'd0, STAT_OK},
    // 33 rounds to 64: no free 64-unit block left
    '{MODE_ALLOC, 9'd33,  8'd0,   1'b0, 8'd0, STAT_OK},
    '{MODE_ALLOC, 9'd32,  8'd0,   1'b0, 8'd0, STAT_OK},
    '{MODE_FREE,  9'd0,   8'd2,   1'b0, 8'd0, STAT_OK},
    '{MODE_FREE,  9'd0,   8'd4,   1'b0, 8'd0, STAT_OK},
    '{MODE_FREE,  9'd0,   8'd130, 1'b0, 8'd0, STAT_OK},
    '{MODE_ALLOC, 9'd2,   8'd0,   1'b0, 8'd0, STAT_OK}
  };

  logic clk = 1'b0;
  logic rst_n;

  bat_req_if req_bus ();
  bat_rsp_if rsp_bus ();

  buddy_allocator_tree DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_bus.sink),
    .out_rsp (rsp_bus.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mirror of the free-space tree: largest free block under each node.
  logic [VAL_W-1:0] free_tree [TREE_NODES];

  rsp_t  pending_replies [$];
  held_t held_blocks [$];
  int    error_count = 0;
  int    cycle_count = 0;
  int    burst_left  = 0;

  // Apply one request to the tree mirror and return the response it earns.
  function automatic rsp_t buddy_predict(input req_t r);
    rsp_t res;
    int   want, need, node, size, left, lval, rval;
    res.off = '0;
    if (r.mode == MODE_ALLOC) begin
      res.st = STAT_NOSPACE;
      need = (r.size == '0) ? 1 : int'(r.size);
      want = 1;
      while (want < need) want = want << 1;
      if (want <= POOL_UNITS && int'(free_tree[0]) >= want) begin
        // descend to the leftmost node of exactly the wanted size
        node = 0;
        size = POOL_UNITS;
        while (size != want && size > 1) begin
          left = 2 * node + 1;
          if (left >= TREE_NODES) break;
          node = (int'(free_tree[left]) >= want) ? left : left + 1;
          size = size >> 1;
        end
        free_tree[node] = '0;
        res.off = OFF_W'((node + 1) * size - POOL_UNITS);
        while (node != 0) begin
          node = (node - 1) / 2;
          lval = int'(free_tree[2 * node + 1]);
          rval = int'(free_tree[2 * node + 2]);
          free_tree[node] = VAL_W'((lval > rval) ? lval : rval);
        end
        res.st = STAT_OK;
      end
    end else begin
      res.st = STAT_IGNORED;
      if (int'(r.off) < POOL_UNITS) begin
        // climb from the leaf to the first allocated node
        node = int'(r.off) + POOL_UNITS - 1;
        size = 1;
        while (free_tree[node] != '0 && node != 0) begin
          size = size << 1;
          node = (node - 1) / 2;
        end
        if (free_tree[node] == '0) begin
          free_tree[node] = VAL_W'(size);
          // merge buddies that are both wholly free on the way back up
          while (node != 0) begin
            node = (node - 1) / 2;
            size = size << 1;
            lval = int'(free_tree[2 * node + 1]);
            rval = int'(free_tree[2 * node + 2]);
            if (lval + rval == size) free_tree[node] = VAL_W'(size);
            else free_tree[node] = VAL_W'((lval > rval) ? lval : rval);
          end
          res.st = STAT_OK;
        end
      end
    end
    return res;
  endfunction

  // Drive one beat, hold it until accepted, then queue its expected response.
  task automatic send_request(input req_t r, input bit typed, input rsp_t typed_rsp);
    rsp_t guess;
    req_bus.valid        <= 1'b1;
    req_bus.mode         <= r.mode;
    req_bus.request_size <= r.size;
    req_bus.block_offset <= r.off;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    guess = buddy_predict(r);
    if (r.mode == MODE_ALLOC && guess.st == STAT_OK) begin
      held_blocks.push_back('{guess.off, r.size});
    end
    pending_replies.push_back(typed ? typed_rsp : guess);
  endtask

  // Sender pacing: keep valid high through a burst, drop it for a random gap
  // between bursts. Gaps run long enough to land on any phase of a tree walk.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 25) : $urandom_range(1, 4);
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
    end
  endtask

  // Receiver stalls: switch between always-ready, random, periodic and long
  // stall patterns, each held for a random stretch.
  int stall_kind = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_kind = $urandom_range(0, 3);
      stall_left = $urandom_range(30, 90);
    end else begin
      stall_left--;
    end
    case (stall_kind)
      0: begin
        rsp_bus.ready <= 1'b1;
      end
      1: begin
        rsp_bus.ready <= ($urandom_range(0, 3) != 0);
      end
      2: begin
        rsp_bus.ready <= ((cycle_count % 7) < 4);
      end
      default: begin
        rsp_bus.ready <= ((cycle_count % 16) < 4);
      end
    endcase
  end

  // Check every response beat against the oldest expectation.
  always @(posedge clk) begin : rsp_check
    rsp_t want_rsp;
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: response beat with none expected: offset %0d status %0d",
                 $time, rsp_bus.granted_offset, rsp_bus.status);
        error_count++;
      end else begin
        want_rsp = pending_replies.pop_front();
        if (rsp_bus.granted_offset !== want_rsp.off) begin
          $display("%0t: granted_offset expected %0d actual %0d",
                   $time, want_rsp.off, rsp_bus.granted_offset);
          error_count++;
        end
        if (rsp_bus.status !== want_rsp.st) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, want_rsp.st, rsp_bus.status);
          error_count++;
        end
      end
    end
  end

  // Watchdog: a stuck handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    req_t     r;
    rsp_t     typed_rsp;
    dir_row_t row;
    held_t    hb;
    int       pick, idx, sz;

    rst_n                <= 1'b0;
    req_bus.valid        <= 1'b0;
    req_bus.mode         <= MODE_ALLOC;
    req_bus.request_size <= '0;
    req_bus.block_offset <= '0;

    // Seed the mirror with every node at its full size.
    sz = 2 * POOL_UNITS;
    for (int k = 0; k < TREE_NODES; k++) begin
      if (((k + 1) & k) == 0) sz = sz >> 1;
      free_tree[k] = VAL_W'(sz);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. The block sweeps its RAM first; ready holds us off.
    for (int i = 0; i < DIR_ROWS; i++) begin
      row           = directed_rows[i];
      r             = '{row.mode, row.size, row.off};
      typed_rsp.off = row.exp_off;
      typed_rsp.st  = row.exp_st;
      send_request(r, row.typed, typed_rsp);
      pace_sender();
    end

    // Random phase: mostly allocate and free of granted blocks, with noise frees
    // of arbitrary offsets. Ignored fields carry random bits throughout.
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      pick   = $urandom_range(0, 99);
      r.size = REQ_W'($urandom);
      r.off  = OFF_W'($urandom);
      if (held_blocks.size() > 0 && (pick < 35 || free_tree[0] < VAL_W'(8))) begin
        idx = $urandom_range(0, held_blocks.size() - 1);
        hb  = held_blocks[idx];
        held_blocks.delete(idx);
        r.mode = MODE_FREE;
        r.off  = hb.off;
        // now and then free from inside the block instead of its start
        if ($urandom_range(0, 9) == 0 && hb.len > 1) begin
          r.off = hb.off + OFF_W'($urandom_range(0, int'(hb.len) - 1));
        end
      end else if (pick < 45) begin
        r.mode = MODE_FREE;
      end else begin
        r.mode = MODE_ALLOC;
        pick   = $urandom_range(0, 99);
        if (pick < 60) r.size = REQ_W'($urandom_range(0, 8));
        else if (pick < 85) r.size = REQ_W'($urandom_range(9, 64));
        else if (pick < 95) r.size = REQ_W'($urandom_range(65, 256));
        else r.size = REQ_W'($urandom_range(257, 511));
      end
      send_request(r, 1'b0, '0);
      pace_sender();
    end

    // Drain: wait out every response, then the block's latency.
    req_bus.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
